// ===== hw/rtl/swrm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the sliding window rate meter.
// Depends on nothing; imported by the interfaces, the divider and the top level.
package swrm_pkg;

   // Field widths
   localparam int TIME_W  = 40;
   localparam int SIZE_W  = 24;
   localparam int RATE_W  = 64;

   // Microseconds per second, the scale of every rate
   localparam int SCALE_W = 20;
   localparam logic [SCALE_W-1:0] US_PER_S = 20'd1000000;

   // Scaled numerator width and divider step counter
   localparam int PROD_W = RATE_W + SCALE_W;
   localparam int STEP_W = $clog2(PROD_W);

   // Item kinds
   localparam logic ACT_PACKET = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START    = 2'd2;

   // Register reset values
   localparam logic [TIME_W-1:0] WINDOW_RESET   = 40'd1000000;
   localparam logic [TIME_W-1:0] INTERVAL_RESET = 40'd200000;
   localparam logic [TIME_W-1:0] START_RESET    = 40'd0;

   // Request to the scaled divider
   typedef struct packed {
      logic              start;
      logic [RATE_W-1:0] num;
      logic [TIME_W-1:0] den;
   } div_req_type;

   // Answer of the scaled divider
   typedef struct packed {
      logic              done;
      logic [RATE_W-1:0] quo;
   } div_rsp_type;

endpackage

// ===== hw/rtl/swrm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the rate meter: item requests and rate responses.
// Depends on swrm_pkg for the field widths.
interface swrm_req_if
   import swrm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [TIME_W-1:0] timestamp_us;
   logic [SIZE_W-1:0] packet_bytes;

   modport source (output valid, output action, output timestamp_us, output packet_bytes,
                   input ready);
   modport sink   (input valid, input action, input timestamp_us, input packet_bytes,
                   output ready);
endinterface

interface swrm_rsp_if
   import swrm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] instant_rate;
   logic [RATE_W-1:0] mean_rate;
   logic              mean_valid;

   modport source (output valid, output instant_rate, output mean_rate, output mean_valid,
                   input ready);
   modport sink   (input valid, input instant_rate, input mean_rate, input mean_valid,
                   output ready);
endinterface

// ===== hw/rtl/sliding_window_rate_meter.sv =====
`timescale 1ns / 1ps
// Top level of the sliding window rate meter: sample ring, sequencer, result register.
// Depends on swrm_pkg, swrm_if, swrm_ram and swrm_div.
//
// Usage. Items arrive on req_ch: a packet beat (action 0) carries a timestamp in
// microseconds and a byte count; a query beat (action 1) carries only a timestamp.
// Every item gives exactly one beat on rsp_ch with the windowed instant rate, the
// mean rate since the start time and its valid flag. The user must write registers
// on the csr_ port only while the block is idle; the block does not enforce this.
// One item is worked on at a time. A query, or a packet that does not trigger a
// recomputation, takes one pass of the shared scaled divider (20 scaling steps plus
// 84 quotient bits) when the mean is valid and no divider pass when it is not. A
// packet that triggers a recomputation adds a read of every stored sample through
// the single ring read port plus, when the oldest kept sample is older than the
// item, a second divider pass.
// Reset clears the ring pointers, the byte total and the held instant rate and
// restores the register defaults; the ring itself needs no clearing.
// A stalled receiver does not hold up the next item: the result register keeps
// its beat, and the following result waits only until that beat is taken.
module sliding_window_rate_meter
   import swrm_pkg::*;
#(
   parameter int RING_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   swrm_req_if.sink             req_ch,
   swrm_rsp_if.source           rsp_ch,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata
);

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = SIZE_W + CNT_W;
   localparam int ENT_W = TIME_W + SIZE_W;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_WRITE     = 7'b0000010,
      ST_SCAN      = 7'b0000100,
      ST_RATE_GO   = 7'b0001000,
      ST_RATE_WAIT = 7'b0010000,
      ST_MEAN      = 7'b0100000,
      ST_MEAN_WAIT = 7'b1000000
   } state_type;

   // Sequencer and item
   state_type           state_ff, state_in;
   logic                out_pend_ff, out_pend_in;
   logic [TIME_W-1:0]   item_ts_ff, item_ts_in;
   logic [SIZE_W-1:0]   item_bytes_ff, item_bytes_in;

   // Registers
   logic [TIME_W-1:0]   window_ff, window_in;
   logic [TIME_W-1:0]   interval_ff, interval_in;
   logic [TIME_W-1:0]   start_ff, start_in;

   // Meter state
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [RATE_W-1:0]   total_ff, total_in;
   logic [TIME_W-1:0]   lut_ff, lut_in;
   logic [RATE_W-1:0]   held_ff, held_in;

   // Ring scan
   logic [IDX_W-1:0]    scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]    scan_len_ff, scan_len_in;
   logic [CNT_W-1:0]    iss_cnt_ff, iss_cnt_in;
   logic [CNT_W-1:0]    rcv_cnt_ff, rcv_cnt_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                dropping_ff, dropping_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [TIME_W-1:0]   oldest_ff, oldest_in;

   // Mean result and response register
   logic [RATE_W-1:0]   mean_ff, mean_in;
   logic                mvalid_ff, mvalid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]   rsp_instant_ff, rsp_instant_in;
   logic [RATE_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic                rsp_mvalid_ff, rsp_mvalid_in;

   // Ring and divider connections
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic                ram_rd_en;
   logic [ENT_W-1:0]    ram_rd_data;
   logic [TIME_W-1:0]   ent_time;
   logic [SIZE_W-1:0]   ent_size;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // Derived values
   logic                ring_full;
   logic [IDX_W:0]      slot_sum;
   logic [IDX_W-1:0]    slot;
   logic                upd_due;
   logic                ent_stale;
   logic                rate_stale;
   logic                out_free;
   logic                req_fire;

   function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] ptr);
      ptr_next = (ptr == IDX_W'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   swrm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({item_ts_ff, item_bytes_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_ptr_ff),
      .rd_data (ram_rd_data)
   );

   swrm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign ent_time = ram_rd_data[ENT_W-1:SIZE_W];
   assign ent_size = ram_rd_data[SIZE_W-1:0];

   // Slot of the new sample: the oldest when full, else just past the newest
   assign ring_full = (count_ff == CNT_W'(RING_DEPTH));
   assign slot_sum  = {1'b0, head_ff} + {1'b0, count_ff[IDX_W-1:0]};
   always_comb begin
      if (slot_sum >= (IDX_W + 1)'(RING_DEPTH)) begin
         slot = IDX_W'(slot_sum - (IDX_W + 1)'(RING_DEPTH));
      end else begin
         slot = slot_sum[IDX_W-1:0];
      end
   end

   // Time comparisons, all one bit wider than a timestamp
   assign upd_due    = ({1'b0, item_ts_ff} >= ({1'b0, lut_ff} + {1'b0, interval_ff}));
   assign ent_stale  = (({1'b0, ent_time} + {1'b0, window_ff}) < {1'b0, item_ts_ff});
   assign rate_stale = ({1'b0, item_ts_ff} >= ({1'b0, lut_ff} + {1'b0, window_ff}));

   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE) && !out_pend_ff;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      out_pend_in    = out_pend_ff;
      item_ts_in     = item_ts_ff;
      item_bytes_in  = item_bytes_ff;
      window_in      = window_ff;
      interval_in    = interval_ff;
      start_in       = start_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      lut_in         = lut_ff;
      held_in        = held_ff;
      scan_ptr_in    = scan_ptr_ff;
      scan_len_in    = scan_len_ff;
      iss_cnt_in     = iss_cnt_ff;
      rcv_cnt_in     = rcv_cnt_ff;
      rd_pend_in     = 1'b0;
      dropping_in    = dropping_ff;
      sum_in         = sum_ff;
      oldest_in      = oldest_ff;
      mean_in        = mean_ff;
      mvalid_in      = mvalid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_instant_in = rsp_instant_ff;
      rsp_mean_in    = rsp_mean_ff;
      rsp_mvalid_in  = rsp_mvalid_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = slot;
      ram_rd_en      = 1'b0;
      div_req.start  = 1'b0;
      div_req.num    = total_ff;
      div_req.den    = TIME_W'(lut_ff - start_ff);

      // Register writes
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_WINDOW:   window_in   = csr_wdata;
            CSR_INTERVAL: interval_in = csr_wdata;
            CSR_START:    start_in    = csr_wdata;
            default:      ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_ts_in     = req_ch.timestamp_us;
               item_bytes_in  = req_ch.packet_bytes;
               state_in       = (req_ch.action == ACT_PACKET) ? ST_WRITE : ST_MEAN;
            end
         end
         ST_WRITE: begin
            // Store the sample and account its bytes
            ram_wr_en = 1'b1;
            total_in  = total_ff + RATE_W'(item_bytes_ff);
            if (ring_full) begin
               head_in  = ptr_next(head_ff);
               count_in = count_ff;
            end else begin
               count_in = count_ff + 1'b1;
            end
            if (upd_due) begin
               lut_in      = item_ts_ff;
               scan_ptr_in = ring_full ? ptr_next(head_ff) : head_ff;
               scan_len_in = ring_full ? count_ff : count_ff + 1'b1;
               iss_cnt_in  = '0;
               rcv_cnt_in  = '0;
               dropping_in = 1'b1;
               sum_in      = '0;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_MEAN;
            end
         end
         ST_SCAN: begin
            // Issue one ring read per cycle from the oldest sample onwards
            if (iss_cnt_ff != scan_len_ff) begin
               ram_rd_en   = 1'b1;
               rd_pend_in  = 1'b1;
               scan_ptr_in = ptr_next(scan_ptr_ff);
               iss_cnt_in  = iss_cnt_ff + 1'b1;
            end
            // Drop stale samples from the front, then sum the kept ones
            if (rd_pend_ff) begin
               rcv_cnt_in = rcv_cnt_ff + 1'b1;
               if (dropping_ff && (count_ff > CNT_W'(1)) && ent_stale) begin
                  head_in  = ptr_next(head_ff);
                  count_in = count_ff - 1'b1;
               end else begin
                  dropping_in = 1'b0;
                  sum_in      = sum_ff + SUM_W'(ent_size);
                  if (dropping_ff) begin
                     oldest_in = ent_time;
                  end
               end
               if (rcv_cnt_ff == scan_len_ff - 1'b1) begin
                  state_in = ST_RATE_GO;
               end
            end
         end
         ST_RATE_GO: begin
            if (oldest_ff >= item_ts_ff) begin
               held_in  = '0;
               state_in = ST_MEAN;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = RATE_W'(sum_ff);
               div_req.den   = TIME_W'(item_ts_ff - oldest_ff);
               state_in      = ST_RATE_WAIT;
            end
         end
         ST_RATE_WAIT: begin
            if (div_rsp.done) begin
               held_in  = div_rsp.quo;
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (lut_ff > start_ff) begin
               div_req.start = 1'b1;
               state_in      = ST_MEAN_WAIT;
            end else begin
               mean_in     = '0;
               mvalid_in   = 1'b0;
               out_pend_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               mean_in     = div_rsp.quo;
               mvalid_in   = 1'b1;
               out_pend_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Hand the finished result to the response register once it is free
      if (out_pend_ff && out_free) begin
         out_pend_in    = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_instant_in = rate_stale ? '0 : held_ff;
         rsp_mean_in    = mean_ff;
         rsp_mvalid_in  = mvalid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         window_ff    <= WINDOW_RESET;
         interval_ff  <= INTERVAL_RESET;
         start_ff     <= START_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         lut_ff       <= '0;
         held_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_pend_ff  <= out_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         window_ff    <= window_in;
         interval_ff  <= interval_in;
         start_ff     <= start_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         lut_ff       <= lut_in;
         held_ff      <= held_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ts_ff     <= item_ts_in;
      item_bytes_ff  <= item_bytes_in;
      scan_ptr_ff    <= scan_ptr_in;
      scan_len_ff    <= scan_len_in;
      iss_cnt_ff     <= iss_cnt_in;
      rcv_cnt_ff     <= rcv_cnt_in;
      dropping_ff    <= dropping_in;
      sum_ff         <= sum_in;
      oldest_ff      <= oldest_in;
      mean_ff        <= mean_in;
      mvalid_ff      <= mvalid_in;
      rsp_instant_ff <= rsp_instant_in;
      rsp_mean_ff    <= rsp_mean_in;
      rsp_mvalid_ff  <= rsp_mvalid_in;
   end

   // Response beat
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.instant_rate = rsp_instant_ff;
   assign rsp_ch.mean_rate    = rsp_mean_ff;
   assign rsp_ch.mean_valid   = rsp_mvalid_ff;

endmodule

// ===== hw/rtl/swrm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the sample ring of the rate meter.
module swrm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/swrm_div.sv =====
`timescale 1ns / 1ps
// Scaled divider: floor(num * 1000000 / den), saturated to 64 bits.
// Depends on swrm_pkg; shift-add scaling, then one restoring bit per cycle.
module swrm_div
   import swrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_MUL  = 3'b010,
      DV_DIV  = 3'b100
   } dv_state_type;

   dv_state_type        state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                done_ff, done_in;
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [SCALE_W-1:0]  mconst_ff, mconst_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [TIME_W-1:0]   den_ff, den_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [RATE_W-1:0]   quo_ff, quo_in;
   logic                sat_ff, sat_in;
   logic [TIME_W:0]     rem_shift;
   logic                q_bit;

   // Partial remainder with the next numerator bit brought down
   assign rem_shift = {rem_ff, prod_ff[PROD_W-1]};
   assign q_bit     = (rem_shift >= {1'b0, den_ff});

   // Sequencer: scale by the constant, then divide
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      mcand_in  = mcand_ff;
      mconst_in = mconst_ff;
      prod_in   = prod_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      sat_in    = sat_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (req.start) begin
               mcand_in  = PROD_W'(req.num);
               mconst_in = US_PER_S;
               prod_in   = '0;
               den_in    = req.den;
               rem_in    = '0;
               quo_in    = '0;
               sat_in    = 1'b0;
               step_in   = '0;
               state_in  = DV_MUL;
            end
         end
         DV_MUL: begin
            if (mconst_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mconst_in = mconst_ff >> 1;
            if (step_ff == STEP_W'(SCALE_W - 1)) begin
               step_in  = '0;
               state_in = DV_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         DV_DIV: begin
            if (q_bit) begin
               rem_in = TIME_W'(rem_shift - {1'b0, den_ff});
            end else begin
               rem_in = rem_shift[TIME_W-1:0];
            end
            prod_in = prod_ff << 1;
            quo_in  = {quo_ff[RATE_W-2:0], q_bit};
            // Any quotient bit above bit 63 means the rate saturates
            sat_in  = sat_ff | quo_ff[RATE_W-1];
            if (step_ff == STEP_W'(PROD_W - 1)) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      mcand_ff  <= mcand_in;
      mconst_ff <= mconst_in;
      prod_ff   <= prod_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      sat_ff    <= sat_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = sat_ff ? {RATE_W{1'b1}} : quo_ff;

endmodule
